### hw/rtl/sbdc_pkg.sv
// sbdc_pkg: shared constants, status codes and the result item type of the
// script bracket depth checker. No dependencies.

package sbdc_pkg;

    // source length counter saturates at 2**LENGTH_BITS
    localparam int LENGTH_BITS = 16;
    localparam int COUNT_W     = LENGTH_BITS + 1;
    // width for comparing the length count against the 16-bit limit
    localparam int CMP_W       = (COUNT_W > 16) ? COUNT_W : 17;

    // status codes; checked as EMPTY, TOO_LONG, NO_DRAW, TOO_DEEP, first match wins, else OK
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_NO_DRAW  = 3'd3,
        ST_TOO_DEEP = 3'd4
    } t_status;

    // one result item
    typedef struct packed {
        t_status              status;
        logic [15:0]          fault_line;
        logic [COUNT_W-1:0]   byte_count;
    } t_result;

endpackage

### hw/rtl/sbdc_scan.sv
// sbdc_scan: per-byte scan state (comment/string mode, nesting depth, line,
// length, draw search) and the result of a closing item.
// Depends on sbdc_pkg.

module sbdc_scan import sbdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_byte_valid,
    input  logic          i_last,
    input  logic [15:0]   i_max_length,
    input  logic [7:0]    i_max_depth,
    output t_result       o_result
);

    typedef enum logic [3:0] {
        M_NORMAL,
        M_DASH1,
        M_DASH2,
        M_DASH3,
        M_LINE,
        M_LONG,
        M_LONG_R,
        M_STR_D,
        M_STR_S,
        M_ESC_D,
        M_ESC_S,
        M_BRACK1
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [8:0]          depth;
        logic [15:0]         line;
        logic [COUNT_W-1:0]  length;
        logic [1:0]          match;
        logic                draw_seen;
        logic                deep_fault;
        logic [15:0]         deep_line;
    } t_scan_state;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_D      = 8'h64;

    localparam logic [7:0] DRAW_TEXT [4] = '{8'h64, 8'h72, 8'h61, 8'h77};

    localparam t_scan_state SCAN_RESET = '{
        mode:       M_NORMAL,
        depth:      9'd0,
        line:       16'd1,
        length:     '0,
        match:      2'd0,
        draw_seen:  1'b0,
        deep_fault: 1'b0,
        deep_line:  16'd0
    };

    t_scan_state r_st;
    t_scan_state n_st;
    t_scan_state s;
    t_scan_state fin;
    logic        do_code;
    logic [2:0]  p;

    // open bracket: saturating depth raise, flag the first level over the limit
    function automatic t_scan_state f_open(t_scan_state st, logic [7:0] max_d);
        t_scan_state o;
        o = st;
        if (o.depth != 9'h1FF) o.depth = o.depth + 9'd1;
        if (o.depth > {1'b0, max_d}) begin
            o.deep_fault = 1'b1;
            o.deep_line  = o.line;
        end
        return o;
    endfunction

    // saturating line advance
    function automatic logic [15:0] f_next_line(logic [15:0] ln);
        return (ln != 16'hFFFF) ? ln + 16'd1 : ln;
    endfunction

    // next scan state for the current item
    always_comb begin
        s       = r_st;
        do_code = 1'b0;
        p       = {1'b0, r_st.match};
        if (i_byte_valid) begin
            if (!s.length[COUNT_W-1]) s.length = s.length + 1'b1;

            // draw search, runs on every byte
            if (i_data_byte == DRAW_TEXT[s.match]) p = p + 3'd1;
            else p = (i_data_byte == CH_D) ? 3'd1 : 3'd0;
            if (p == 3'd4) begin
                s.draw_seen = 1'b1;
                p = 3'd0;
            end
            s.match = p[1:0];

            // mode transitions, frozen once nesting has gone too deep
            if (!s.deep_fault) begin
                case (s.mode)
                    M_NORMAL: do_code = 1'b1;
                    M_DASH1: begin
                        if (i_data_byte == CH_DASH) s.mode = M_DASH2;
                        else do_code = 1'b1;
                    end
                    M_DASH2, M_DASH3: begin
                        if (i_data_byte == CH_LBRACK) begin
                            s.mode = (s.mode == M_DASH2) ? M_DASH3 : M_LONG;
                        end else if (i_data_byte == CH_NL) begin
                            s.line = f_next_line(s.line);
                            s.mode = M_NORMAL;
                        end else begin
                            s.mode = M_LINE;
                        end
                    end
                    M_LINE: begin
                        if (i_data_byte == CH_NL) begin
                            s.line = f_next_line(s.line);
                            s.mode = M_NORMAL;
                        end
                    end
                    M_LONG: begin
                        if (i_data_byte == CH_RBRACK) s.mode = M_LONG_R;
                    end
                    M_LONG_R: s.mode = (i_data_byte == CH_RBRACK) ? M_NORMAL : M_LONG;
                    M_STR_D: begin
                        if (i_data_byte == CH_BSLASH) s.mode = M_ESC_D;
                        else if (i_data_byte == CH_DQUOTE) s.mode = M_NORMAL;
                    end
                    M_STR_S: begin
                        if (i_data_byte == CH_BSLASH) s.mode = M_ESC_S;
                        else if (i_data_byte == CH_SQUOTE) s.mode = M_NORMAL;
                    end
                    M_ESC_D: s.mode = M_STR_D;
                    M_ESC_S: s.mode = M_STR_S;
                    M_BRACK1: begin
                        if (i_data_byte == CH_LBRACK) begin
                            s.mode = M_LONG;
                        end else begin
                            // pending open bracket was a plain bracket
                            s.mode  = M_NORMAL;
                            s       = f_open(s, i_max_depth);
                            do_code = !s.deep_fault;
                        end
                    end
                    default: s.mode = M_NORMAL;
                endcase

                // plain code byte
                if (do_code) begin
                    s.mode = M_NORMAL;
                    case (i_data_byte)
                        CH_NL:     s.line = f_next_line(s.line);
                        CH_DASH:   s.mode = M_DASH1;
                        CH_DQUOTE: s.mode = M_STR_D;
                        CH_SQUOTE: s.mode = M_STR_S;
                        CH_LBRACK: s.mode = M_BRACK1;
                        CH_LPAREN, CH_LBRACE: s = f_open(s, i_max_depth);
                        CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
                            if (s.depth != 9'd0) s.depth = s.depth - 9'd1;
                        end
                        default: ;
                    endcase
                end
            end
        end

        // closing item: an open bracket as final byte still counts
        fin = s;
        if (fin.mode == M_BRACK1 && !fin.deep_fault) fin = f_open(fin, i_max_depth);

        o_result.fault_line = 16'd0;
        o_result.byte_count = fin.length;
        if (fin.length == '0) begin
            o_result.status = ST_EMPTY;
        end else if (CMP_W'(fin.length) > CMP_W'(i_max_length)) begin
            o_result.status = ST_TOO_LONG;
        end else if (!fin.draw_seen) begin
            o_result.status = ST_NO_DRAW;
        end else if (fin.deep_fault) begin
            o_result.status     = ST_TOO_DEEP;
            o_result.fault_line = fin.deep_line;
        end else begin
            o_result.status = ST_OK;
        end

        n_st = i_last ? SCAN_RESET : s;
    end

    // scan state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SCAN_RESET;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

### hw/rtl/script_bracket_depth_checker.sv
// script_bracket_depth_checker: top level with configuration registers,
// result register and skid stage. Depends on sbdc_pkg and sbdc_scan.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | i_valid / o_stall    | i_data_byte, i_byte_valid, i_last
//  result   | o_valid / i_stall    | o_status, o_fault_line, o_byte_count
//  config   | i_cfg_we             | i_cfg_index, i_cfg_wdata
//
// one item per cycle while o_stall is low; the scan state register is updated on every accepted item
// the result of a closing item is registered in the result register, or in the skid stage if stalled
// reset is synchronous: scan state back to normal code, limits to 24576 / 32
// o_stall rises only when both the result register and the skid stage are full

module script_bracket_depth_checker import sbdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_byte_valid,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [15:0]         o_fault_line,
    output logic [COUNT_W-1:0]  o_byte_count,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_wdata
);

    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_MAX_DEPTH  = 1'b1;

    logic [15:0] r_max_length;
    logic [7:0]  r_max_depth;
    logic        in_accept;
    logic        out_free;
    logic        new_res;
    t_result     scan_res;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign new_res   = in_accept && i_last;
    assign out_free  = !r_out_valid || !i_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= 16'd24576;
            r_max_depth  <= 8'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata;
                CFG_MAX_DEPTH:  r_max_depth  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // scanner
    sbdc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_max_length (r_max_length),
        .i_max_depth  (r_max_depth),
        .o_result     (scan_res)
    );

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || new_res;
            r_skid_valid <= 1'b0;
        end else if (new_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : scan_res;
        end else if (new_res) begin
            r_skid <= scan_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out.status;
    assign o_fault_line = r_out.fault_line;
    assign o_byte_count = r_out.byte_count;

endmodule

### hw/rtl/sbdc_checker.sv
// sbdc_checker: port-level assertions for script_bracket_depth_checker and
// the bind that attaches them. Depends on sbdc_pkg.

module sbdc_checker import sbdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_stall,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic [2:0]          o_status,
    input  logic [15:0]         o_fault_line,
    input  logic [COUNT_W-1:0]  o_byte_count
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_fault_line) && $stable(o_byte_count))
        else $error("result item changed while stalled");

    // input is held back only while a result waits
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // empty status exactly when no byte was counted
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_EMPTY) == (o_byte_count == '0)))
        else $error("empty status and byte count disagree");

    // fault line given only, and always, for the too-deep status
    a_fault_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_TOO_DEEP) == (o_fault_line != 16'd0)))
        else $error("fault line does not match status");

    // reset empties the result side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result side not cleared by reset");

endmodule

bind script_bracket_depth_checker sbdc_checker u_sbdc_checker (.*);
